/* rtl/ssra_pkg.sv */
package ssra_pkg;

  localparam int SENSOR_REGS   = 64;
  localparam int ACTUATOR_REGS = 64;
  localparam int SENS_AW       = (SENSOR_REGS > 1) ? $clog2(SENSOR_REGS) : 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_INIT  = 2'd1,
    OP_START = 2'd2,
    OP_LOAD  = 2'd3
  } op_t;

  localparam logic [7:0] CMD_READ  = 8'd1;
  localparam logic [7:0] CMD_WRITE = 8'd2;

  typedef enum logic [2:0] {
    PH_CMD  = 3'b001,
    PH_ADDR = 3'b010,
    PH_DATA = 3'b100
  } phase_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] rx_byte;
    logic [5:0] sensor_index;
    logic [7:0] sensor_value;
  } req_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       act_write_valid;
    logic [5:0] act_write_index;
    logic [7:0] act_write_value;
    logic       sensor_lock_held;
    logic       actuator_lock_held;
  } rsp_t;

  // Classified request as it travels through the queue
  typedef struct packed {
    op_t                kind;
    logic               load_ok;
    logic [7:0]         rx_byte;
    logic [SENS_AW-1:0] load_index;
    logic [7:0]         load_value;
  } item_t;

endpackage

/* rtl/spi_slave_register_access_core.sv */
// Path: a request accepted into the queue is popped into the response register when the response
// side does not stall, and its response is then valid from that register.
// Throughput: one request per cycle while the queue is not full; the two-entry queue and the response register
// keep responses flowing each cycle while the response side does not stall; the request side sees stall
// while the queue is full, which lasts until the queue is popped after a response stall ends.
// Reset (rst, synchronous): engine stopped, counters and locks cleared, sensor bank reads zero.
module spi_slave_register_access_core
  import ssra_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  logic  full;
  logic  push;
  item_t item;
  logic  pop;
  logic  head_valid;
  item_t head_item;

  ssra_front u_front (
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .full      (full),
    .push      (push),
    .item      (item)
  );

  ssra_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (item),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  ssra_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp)
  );

endmodule

/* rtl/ssra_front.sv */
module ssra_front
  import ssra_pkg::*;
(
  input  logic  req_valid,
  output logic  req_stall,
  input  req_t  req,
  input  logic  full,
  output logic  push,
  output item_t item
);

  logic [7:0] idx_ext;

  assign idx_ext   = {2'b00, req.sensor_index};
  assign req_stall = full;
  assign push      = req_valid && !full;

  always_comb begin
    item.kind       = op_t'(req.operation);
    item.load_ok    = ({3'b000, req.sensor_index} < 9'(SENSOR_REGS));
    item.rx_byte    = req.rx_byte;
    item.load_index = idx_ext[SENS_AW-1:0];
    item.load_value = req.sensor_value;
  end

endmodule

/* rtl/ssra_queue.sv */
module ssra_queue
  import ssra_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output item_t head_item
);

  item_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_ptr;
  logic [QUEUE_AW-1:0]  rd_ptr;
  logic [QUEUE_AW:0]    count;

  assign full       = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      priority if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/ssra_back.sv */
module ssra_back
  import ssra_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  head_valid,
  input  item_t head_item,
  output logic  pop,
  output logic  rsp_valid,
  input  logic  rsp_stall,
  output rsp_t  rsp
);

  // transaction state
  logic       running;
  phase_t     phase;
  logic [7:0] command_byte;
  logic [7:0] base_address;
  logic [7:0] read_offset;
  logic [7:0] write_offset;
  logic       lock_s;
  logic       lock_a;

  logic       running_next;
  phase_t     phase_next;
  logic [7:0] command_byte_next;
  logic [7:0] base_address_next;
  logic [7:0] read_offset_next;
  logic [7:0] write_offset_next;
  logic       lock_s_next;
  logic       lock_a_next;

  // sensor bank
  logic [7:0]       sensor_mem [SENSOR_REGS];
  logic [SENSOR_REGS-1:0] sensor_vld;
  logic [7:0]       mem_q;

  // result register
  logic       tx_valid_q;
  logic       tx_mem_q;
  logic [7:0] tx_imm_q;
  logic       rd_hit_q;
  logic       awv_q;
  logic [5:0] awi_q;
  logic [7:0] awd_q;

  logic               adv;
  logic [7:0]         a_rd;
  logic [7:0]         a_wr;
  logic               tx_v;
  logic               tx_mem;
  logic [7:0]         tx_imm;
  logic               rd_en;
  logic               rd_ok;
  logic [SENS_AW-1:0] rd_idx;
  logic               ld_en;
  logic               awv;
  logic [5:0]         awi;
  logic [7:0]         awd;

  assign adv  = !rsp_valid || !rsp_stall;
  assign pop  = head_valid && adv;
  assign a_rd = base_address + read_offset;
  assign a_wr = base_address + write_offset;

  always_comb begin
    running_next      = running;
    phase_next        = phase;
    command_byte_next = command_byte;
    base_address_next = base_address;
    read_offset_next  = read_offset;
    write_offset_next = write_offset;
    lock_s_next       = lock_s;
    lock_a_next       = lock_a;
    tx_v              = 1'b0;
    tx_mem            = 1'b0;
    tx_imm            = 8'd0;
    rd_en             = 1'b0;
    rd_ok             = 1'b0;
    rd_idx            = a_rd[SENS_AW-1:0];
    ld_en             = 1'b0;
    awv               = 1'b0;
    awi               = 6'd0;
    awd               = 8'd0;
    unique case (head_item.kind)
      OP_INIT: begin
        running_next      = 1'b0;
        phase_next        = PH_CMD;
        command_byte_next = 8'd0;
        base_address_next = 8'd0;
        read_offset_next  = 8'd0;
        write_offset_next = 8'd0;
        lock_s_next       = 1'b0;
        lock_a_next       = 1'b0;
        tx_v              = 1'b1;
      end
      OP_START: begin
        running_next = 1'b1;
      end
      OP_LOAD: begin
        ld_en = head_item.load_ok;
      end
      OP_BYTE: begin
        if (running) begin
          unique case (phase)
            PH_CMD: begin
              command_byte_next = head_item.rx_byte;
              tx_v              = 1'b1;
              tx_imm            = head_item.rx_byte;
              phase_next        = PH_ADDR;
            end
            PH_ADDR: begin
              base_address_next = head_item.rx_byte;
              tx_v              = 1'b1;
              tx_imm            = head_item.rx_byte;
              phase_next        = PH_DATA;
            end
            PH_DATA: begin
              priority if (command_byte == CMD_READ) begin
                lock_s_next      = 1'b1;
                tx_v             = 1'b1;
                tx_mem           = 1'b1;
                rd_en            = 1'b1;
                rd_ok            = ({1'b0, a_rd} < 9'(SENSOR_REGS));
                read_offset_next = read_offset + 8'd1;
              end else if (command_byte == CMD_WRITE) begin
                lock_a_next = 1'b1;
                if ({1'b0, a_wr} < 9'(ACTUATOR_REGS)) begin
                  awv               = 1'b1;
                  awi               = a_wr[5:0];
                  awd               = head_item.rx_byte;
                  write_offset_next = write_offset + 8'd1;
                end
              end else begin
                // unknown command: drop the data byte
              end
            end
            default: begin
              phase_next = PH_CMD;
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop && ld_en) begin
      sensor_mem[head_item.load_index] <= head_item.load_value;
    end
    if (pop && rd_en) begin
      mem_q <= sensor_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      tx_valid_q <= tx_v;
      tx_mem_q   <= tx_mem;
      tx_imm_q   <= tx_imm;
      rd_hit_q   <= rd_ok && sensor_vld[rd_idx];
      awv_q      <= awv;
      awi_q      <= awi;
      awd_q      <= awd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running      <= 1'b0;
      phase        <= PH_CMD;
      command_byte <= 8'd0;
      base_address <= 8'd0;
      read_offset  <= 8'd0;
      write_offset <= 8'd0;
      lock_s       <= 1'b0;
      lock_a       <= 1'b0;
      sensor_vld   <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      if (pop) begin
        running      <= running_next;
        phase        <= phase_next;
        command_byte <= command_byte_next;
        base_address <= base_address_next;
        read_offset  <= read_offset_next;
        write_offset <= write_offset_next;
        lock_s       <= lock_s_next;
        lock_a       <= lock_a_next;
        if (ld_en) begin
          sensor_vld[head_item.load_index] <= 1'b1;
        end
        rsp_valid <= 1'b1;
      end else if (adv) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    rsp.tx_valid           = tx_valid_q;
    rsp.tx_byte            = tx_mem_q ? (rd_hit_q ? mem_q : 8'd0) : tx_imm_q;
    rsp.act_write_valid    = awv_q;
    rsp.act_write_index    = awi_q;
    rsp.act_write_value    = awd_q;
    rsp.sensor_lock_held   = lock_s;
    rsp.actuator_lock_held = lock_a;
  end

endmodule

/* rtl/ssra_checker.sv */
module ssra_checker
  import ssra_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_stall |=> req_valid && $stable(req))
    else $error("stalled request changed");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

  a_tx_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.tx_valid |-> rsp.tx_byte == 8'd0)
    else $error("transmit byte set without transmit valid");

  a_act_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.act_write_valid |->
      rsp.act_write_index == 6'd0 && rsp.act_write_value == 8'd0)
    else $error("actuator fields set without write valid");

  a_write_lock: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.act_write_valid |-> rsp.actuator_lock_held && !rsp.tx_valid)
    else $error("actuator write without lock or with transmit byte");

endmodule

bind spi_slave_register_access_core ssra_checker u_ssra_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

/* dv/ssra_reply_checker.sv */
module ssra_reply_checker
  import ssra_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_stall,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_stall,
  input  rsp_t rsp,
  output int   errors,
  output int   pending
);

  logic       running;
  phase_t     phase;
  logic [7:0] cmd_byte;
  logic [7:0] base_addr;
  logic [7:0] rd_off;
  logic [7:0] wr_off;
  logic       sens_lock;
  logic       act_lock;
  logic [7:0] sensor_bank [SENSOR_REGS];

  rsp_t replies_due [$];
  int   fail_cnt = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] reply mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    fail_cnt++;
  endtask

  task automatic clear_txn();
    phase     = PH_CMD;
    cmd_byte  = '0;
    base_addr = '0;
    rd_off    = '0;
    wr_off    = '0;
    sens_lock = 1'b0;
    act_lock  = 1'b0;
  endtask

  always @(posedge clk) begin : watch
    rsp_t       want;
    logic [7:0] addr;
    if (rst) begin
      running = 1'b0;
      clear_txn();
      for (int i = 0; i < SENSOR_REGS; i++) sensor_bank[i] = '0;
      replies_due.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (replies_due.size() == 0) begin
          report_mismatch("unexpected reply", int'(rsp), 0);
        end else begin
          want = replies_due.pop_front();
          if (rsp.tx_valid !== want.tx_valid)
            report_mismatch("tx_valid", int'(rsp.tx_valid), int'(want.tx_valid));
          if (rsp.tx_byte !== want.tx_byte)
            report_mismatch("tx_byte", int'(rsp.tx_byte), int'(want.tx_byte));
          if (rsp.act_write_valid !== want.act_write_valid)
            report_mismatch("act_write_valid", int'(rsp.act_write_valid),
                            int'(want.act_write_valid));
          if (rsp.act_write_index !== want.act_write_index)
            report_mismatch("act_write_index", int'(rsp.act_write_index),
                            int'(want.act_write_index));
          if (rsp.act_write_value !== want.act_write_value)
            report_mismatch("act_write_value", int'(rsp.act_write_value),
                            int'(want.act_write_value));
          if (rsp.sensor_lock_held !== want.sensor_lock_held)
            report_mismatch("sensor_lock_held", int'(rsp.sensor_lock_held),
                            int'(want.sensor_lock_held));
          if (rsp.actuator_lock_held !== want.actuator_lock_held)
            report_mismatch("actuator_lock_held", int'(rsp.actuator_lock_held),
                            int'(want.actuator_lock_held));
        end
      end

      if (req_valid && !req_stall) begin
        want = '0;
        case (op_t'(req.operation))
          OP_INIT: begin
            running = 1'b0;
            clear_txn();
            want.tx_valid = 1'b1;
          end
          OP_START: running = 1'b1;
          OP_LOAD: begin
            if (req.sensor_index < SENSOR_REGS) sensor_bank[req.sensor_index] = req.sensor_value;
          end
          default: begin
            if (running) begin
              case (phase)
                PH_CMD: begin
                  cmd_byte      = req.rx_byte;
                  want.tx_valid = 1'b1;
                  want.tx_byte  = req.rx_byte;
                  phase         = PH_ADDR;
                end
                PH_ADDR: begin
                  base_addr     = req.rx_byte;
                  want.tx_valid = 1'b1;
                  want.tx_byte  = req.rx_byte;
                  phase         = PH_DATA;
                end
                default: begin
                  if (cmd_byte == CMD_READ) begin
                    addr          = base_addr + rd_off;
                    sens_lock     = 1'b1;
                    want.tx_valid = 1'b1;
                    want.tx_byte  = (addr < SENSOR_REGS) ? sensor_bank[addr[SENS_AW-1:0]] : 8'h00;
                    rd_off        = rd_off + 8'd1;
                  end else if (cmd_byte == CMD_WRITE) begin
                    addr     = base_addr + wr_off;
                    act_lock = 1'b1;
                    // the offset sticks once the address leaves the actuator bank
                    if (addr < ACTUATOR_REGS) begin
                      want.act_write_valid = 1'b1;
                      want.act_write_index = addr[5:0];
                      want.act_write_value = req.rx_byte;
                      wr_off               = wr_off + 8'd1;
                    end
                  end
                end
              endcase
            end
          end
        endcase
        want.sensor_lock_held   = sens_lock;
        want.actuator_lock_held = act_lock;
        replies_due.push_back(want);
      end
    end
    errors  <= fail_cnt;
    pending <= replies_due.size();
  end

endmodule

/* dv/spi_slave_register_access_core_tb.sv */
module spi_slave_register_access_core_tb;
  import ssra_pkg::*;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  req_t req       = '0;
  logic rsp_stall = 1'b0;
  logic req_stall;
  logic rsp_valid;
  rsp_t rsp;
  int   errors;
  int   pending;
  int   sent      = 0;
  int   calm_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  spi_slave_register_access_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  ssra_reply_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Response side: stall in runs of random length, with the odd long quiet stretch
  initial begin : stall_gen
    int p;
    int len;
    forever begin
      @(posedge clk);
      p = $urandom_range(0, 99);
      if (p < 10) begin
        rsp_stall <= 1'b0;
        len = $urandom_range(40, 150);
      end else if (p < 55) begin
        rsp_stall <= 1'b0;
        len = $urandom_range(1, 6);
      end else begin
        rsp_stall <= 1'b1;
        p = $urandom_range(0, 99);
        if (p < 70) len = $urandom_range(1, 2);
        else if (p < 95) len = $urandom_range(3, 8);
        else len = $urandom_range(20, 60);
      end
      if (len > 1) repeat (len - 1) @(posedge clk);
    end
  end

  function automatic int next_gap();
    int p;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    p = $urandom_range(0, 99);
    if (p < 3) begin
      calm_left = $urandom_range(20, 80);
      return 0;
    end
    if (p < 60) return 0;
    if (p < 88) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic req_t rand_req();
    req_t r;
    r.operation    = 2'($urandom_range(0, 3));
    r.rx_byte      = 8'($urandom_range(0, 255));
    r.sensor_index = 6'($urandom_range(0, 63));
    r.sensor_value = 8'($urandom_range(0, 255));
    return r;
  endfunction

  // Hold the request until it is taken
  task automatic send(input req_t r);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    req_t r;
    r           = rand_req();
    r.operation = OP_BYTE;
    r.rx_byte   = b;
    send(r);
  endtask

  task automatic send_ctl(input op_t op);
    req_t r;
    r           = rand_req();
    r.operation = op;
    send(r);
  endtask

  task automatic send_load(input logic [5:0] idx, input logic [7:0] val);
    req_t r;
    r              = rand_req();
    r.operation    = OP_LOAD;
    r.sensor_index = idx;
    r.sensor_value = val;
    send(r);
  endtask

  task automatic run_txn(input logic [7:0] cmd, input logic [7:0] addr, input int n);
    send_ctl(OP_START);
    send_byte(cmd);
    send_byte(addr);
    repeat (n) send_byte(8'($urandom_range(0, 255)));
  endtask

  // Drop valid and wait for every outstanding reply
  task automatic drain();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin : stimulus
    int         p;
    int         n;
    logic [7:0] cmd;
    logic [7:0] addr;
    bit         long_done;
    long_done = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_byte(8'hFF);
    send_load(6'd0, 8'hFF);
    send_load(6'd63, 8'hA5);
    send_ctl(OP_START);
    send_ctl(OP_START);
    // read across the end of the sensor bank
    send_byte(CMD_READ);
    send_byte(8'd63);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_ctl(OP_INIT);
    // second write falls out of range but still takes the lock
    run_txn(CMD_WRITE, 8'd63, 0);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_ctl(OP_INIT);
    run_txn(8'h55, 8'd3, 1);
    send_ctl(OP_INIT);
    // address 255 reads zero, then wraps round to register 0
    run_txn(CMD_READ, 8'hFF, 2);
    drain();

    while (sent < 950) begin
      p = $urandom_range(0, 99);
      if (!long_done && sent > 400) begin
        // long enough for the read offset to wrap
        run_txn(CMD_READ, 8'($urandom_range(0, 255)), 260);
        send_ctl(OP_INIT);
        long_done = 1'b1;
      end else if (p < 72) begin
        repeat ($urandom_range(0, 2))
          send_load(6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1) == 1) send_ctl(OP_INIT);
        p = $urandom_range(0, 99);
        if (p < 45) cmd = CMD_READ;
        else if (p < 85) cmd = CMD_WRITE;
        else cmd = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 3) == 0) addr = 8'($urandom_range(0, 255));
        else addr = 8'($urandom_range(0, 70));
        if ($urandom_range(0, 9) == 0) n = $urandom_range(13, 70);
        else n = $urandom_range(0, 12);
        run_txn(cmd, addr, n);
        if ($urandom_range(0, 3) != 0) send_ctl(OP_INIT);
      end else if (p < 90) begin
        send(rand_req());
      end else if (p < 96) begin
        // broken transaction: abandon after the command byte
        send_ctl(OP_START);
        send_byte(8'($urandom_range(0, 255)));
        send_ctl(OP_INIT);
      end else begin
        drain();
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/ssra_pkg.sv
rtl/ssra_front.sv
rtl/ssra_queue.sv
rtl/ssra_back.sv
rtl/spi_slave_register_access_core.sv
rtl/ssra_checker.sv
dv/ssra_reply_checker.sv
dv/spi_slave_register_access_core_tb.sv
